/* src/bsam_pkg.sv */
// ----------------------------------------------------------------------------
// bsam_pkg
// Shared types and constants for the cartridge bank-switching address mapper.
// ----------------------------------------------------------------------------
package bsam_pkg;

    typedef enum logic [1:0] {
        OP_CPU_WRITE = 2'd0,
        OP_CPU_READ  = 2'd1,
        OP_CHR_READ  = 2'd2,
        OP_RESERVED  = 2'd3
    } opcode_t;

    localparam int unsigned BANK_COUNT   = 8;
    localparam int unsigned BANK_IDX_W   = 3;
    localparam int unsigned BANK_W       = 8;
    localparam int unsigned OFFSET_W     = 19;
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned PRG_BANK_W   = 6;
    localparam int unsigned LOW_W        = 13;

    localparam logic [CNT_W-1:0] PRG_BANK_COUNT_RESET = 7'd64;

    // Bank register indexes that bound the special load rules, and the first 1KB graphics bank.
    localparam logic [BANK_IDX_W-1:0] BANK_CHR_2K_LAST = 3'd1;
    localparam logic [BANK_IDX_W-1:0] BANK_PRG_FIRST   = 3'd6;
    localparam logic [BANK_IDX_W-1:0] BANK_PRG_SECOND  = 3'd7;
    localparam logic [BANK_IDX_W-1:0] BANK_CHR_1K_BASE = 3'd2;

    // Top address bits of the register windows and of the graphics space.
    localparam logic [2:0] WIN_BANK_CTRL  = 3'b100;
    localparam logic [2:0] WIN_MIRROR     = 3'b101;
    localparam logic [2:0] WIN_CHR_SPACE  = 3'b000;

endpackage

/* src/bank_switch_address_mapper.sv */
// An accepted transaction is held in stage 1 while its bank entry is read, and
// its result is then registered in the output register; an output stall holds both.
// Throughput: one transaction per cycle while the output is not stalled; the bank
// memory has one read and one write port, and each transaction uses at most one of them.
// Reset: the bank count returns to 64, mirroring to horizontal, all other
// control state and the bank registers to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// bank_switch_address_mapper
// Translates CPU and pattern-table accesses into program and graphics memory
// offsets, with the eight bank registers held in a small synchronous memory.
// ----------------------------------------------------------------------------
module bank_switch_address_mapper
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [bsam_pkg::CNT_W-1:0]           cfg_wdata,

    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [1:0]                           opcode,
    input  logic [15:0]                          address,
    input  logic [7:0]                           write_value,

    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic [bsam_pkg::OFFSET_W-1:0]        mapped_offset,
    output logic                                 mapped_valid,
    output logic                                 mirror_horizontal
);

    typedef enum logic [2:0] {
        K_NONE,
        K_DIRECT,
        K_PRG_MEM,
        K_PRG_FIXED,
        K_CHR
    } kind_t;

    // Control registers
    logic [bsam_pkg::CNT_W-1:0]      prg_bank_count_reg;
    logic [bsam_pkg::BANK_IDX_W-1:0] register_select_reg, register_select_next;
    logic                            prg_swap_mode_reg, prg_swap_mode_next;
    logic                            chr_invert_reg, chr_invert_next;
    logic                            mirroring_reg, mirroring_next;

    // Bank register memory with per-entry valid bits (unwritten reads as zero)
    logic [bsam_pkg::BANK_W-1:0]     bank_mem [bsam_pkg::BANK_COUNT];
    logic [bsam_pkg::BANK_COUNT-1:0] bank_vld_reg;
    logic [bsam_pkg::BANK_W-1:0]     rd_data_reg;
    logic                            rd_vld_reg;

    logic                            mem_we;
    logic [bsam_pkg::BANK_IDX_W-1:0] mem_waddr;
    logic [bsam_pkg::BANK_W-1:0]     mem_wdata;
    logic                            mem_re;
    logic [bsam_pkg::BANK_IDX_W-1:0] mem_raddr;

    // Stage 1: memory read in flight
    logic                              s1_valid_reg;
    kind_t                             s1_kind_reg, s1_kind_next;
    logic [bsam_pkg::LOW_W-1:0]        s1_low_reg, s1_low_next;
    logic [bsam_pkg::PRG_BANK_W-1:0]   s1_fixed_reg, s1_fixed_next;
    logic                              s1_mirror_reg;

    // Output register
    logic                              rsp_valid_reg;
    logic [bsam_pkg::OFFSET_W-1:0]     rsp_offset_reg, rsp_offset_next;
    logic                              rsp_mapped_reg, rsp_mapped_next;
    logic                              rsp_mirror_reg;

    logic                              req_accept;
    logic                              s1_advance;
    logic                              rsp_free;

    bsam_pkg::opcode_t                 op;
    logic [1:0]                        prg_window;
    logic [12:0]                       chr_addr;
    logic [bsam_pkg::PRG_BANK_W-1:0]   cnt_minus_one;
    logic [bsam_pkg::PRG_BANK_W-1:0]   cnt_minus_two;
    logic [bsam_pkg::BANK_W-1:0]       bank_value;

    assign op            = bsam_pkg::opcode_t'(opcode);
    assign cnt_minus_one = prg_bank_count_reg[bsam_pkg::PRG_BANK_W-1:0] - 6'd1;
    assign cnt_minus_two = prg_bank_count_reg[bsam_pkg::PRG_BANK_W-1:0] - 6'd2;

    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign s1_advance = s1_valid_reg && rsp_free;
    assign req_stall  = s1_valid_reg && !rsp_free;
    assign req_accept = req_valid && !req_stall;

    // Mode 1 swaps the first and third program windows.
    assign prg_window = (prg_swap_mode_reg && !address[13]) ?
                        (address[14:13] ^ 2'b10) : address[14:13];
    assign chr_addr   = address[12:0] ^ {chr_invert_reg, 12'b0};

    // Decode of the incoming transaction: state updates and memory access.
    always_comb
    begin
        register_select_next = register_select_reg;
        prg_swap_mode_next   = prg_swap_mode_reg;
        chr_invert_next      = chr_invert_reg;
        mirroring_next       = mirroring_reg;
        mem_we               = 1'b0;
        mem_waddr            = register_select_reg;
        mem_wdata            = write_value;
        mem_re               = 1'b0;
        mem_raddr            = bsam_pkg::BANK_PRG_FIRST;
        s1_kind_next         = K_NONE;
        s1_low_next          = address[12:0];
        s1_fixed_next        = cnt_minus_one;

        unique case (op)
            bsam_pkg::OP_CPU_WRITE:
            begin
                if (address[15:13] == bsam_pkg::WIN_BANK_CTRL) begin
                    if (!address[0]) begin
                        register_select_next = write_value[2:0];
                        prg_swap_mode_next   = write_value[6];
                        chr_invert_next      = write_value[7];
                    end
                    else begin
                        mem_we = req_accept;
                        if (register_select_reg <= bsam_pkg::BANK_CHR_2K_LAST)
                            mem_wdata = {write_value[7:1], 1'b0};
                        else if (register_select_reg >= bsam_pkg::BANK_PRG_FIRST)
                            mem_wdata = {2'b00, write_value[5:0] & cnt_minus_one};
                        else
                            mem_wdata = write_value;
                    end
                end
                else if (address[15:13] == bsam_pkg::WIN_MIRROR && !address[0]) begin
                    mirroring_next = write_value[0];
                end
            end
            bsam_pkg::OP_CPU_READ:
            begin
                if (address[15]) begin
                    unique case (prg_window)
                        2'd0:
                        begin
                            s1_kind_next = K_PRG_MEM;
                            mem_re       = req_accept;
                            mem_raddr    = bsam_pkg::BANK_PRG_FIRST;
                        end
                        2'd1:
                        begin
                            s1_kind_next = K_PRG_MEM;
                            mem_re       = req_accept;
                            mem_raddr    = bsam_pkg::BANK_PRG_SECOND;
                        end
                        2'd2:
                        begin
                            s1_kind_next  = K_PRG_FIXED;
                            s1_fixed_next = cnt_minus_two;
                        end
                        default:
                        begin
                            s1_kind_next  = K_PRG_FIXED;
                            s1_fixed_next = cnt_minus_one;
                        end
                    endcase
                end
                else if (address[14:13] == 2'b11) begin
                    s1_kind_next = K_DIRECT;
                end
            end
            bsam_pkg::OP_CHR_READ:
            begin
                if (address[15:13] == bsam_pkg::WIN_CHR_SPACE) begin
                    s1_kind_next = K_CHR;
                    mem_re       = req_accept;
                    if (!chr_addr[12]) begin
                        mem_raddr   = {2'b00, chr_addr[11]};
                        s1_low_next = {2'b00, chr_addr[10:0]};
                    end
                    else begin
                        mem_raddr   = bsam_pkg::BANK_CHR_1K_BASE + {1'b0, chr_addr[11:10]};
                        s1_low_next = {3'b000, chr_addr[9:0]};
                    end
                end
            end
            default:
            begin
                s1_kind_next = K_NONE;
            end
        endcase
    end

    // Configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prg_bank_count_reg  <= bsam_pkg::PRG_BANK_COUNT_RESET;
            register_select_reg <= '0;
            prg_swap_mode_reg   <= 1'b0;
            chr_invert_reg      <= 1'b0;
            mirroring_reg       <= 1'b1;
            bank_vld_reg        <= '0;
        end
        else begin
            if (cfg_we)
                prg_bank_count_reg <= cfg_wdata;
            if (req_accept) begin
                register_select_reg <= register_select_next;
                prg_swap_mode_reg   <= prg_swap_mode_next;
                chr_invert_reg      <= chr_invert_next;
                mirroring_reg       <= mirroring_next;
            end
            if (mem_we)
                bank_vld_reg[mem_waddr] <= 1'b1;
        end
    end

    // Bank memory. A write and a read never fall in the same cycle, and a read
    // in the cycle after a write already sees the new entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bank_mem[mem_waddr] <= mem_wdata;
        if (mem_re) begin
            rd_data_reg <= bank_mem[mem_raddr];
            rd_vld_reg  <= bank_vld_reg[mem_raddr];
        end
    end

    // Stage 1 holds the transaction while its bank entry is read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept) begin
            s1_kind_reg   <= s1_kind_next;
            s1_low_reg    <= s1_low_next;
            s1_fixed_reg  <= s1_fixed_next;
            s1_mirror_reg <= mirroring_next;
        end
    end

    assign bank_value = rd_vld_reg ? rd_data_reg : '0;

    always_comb
    begin
        rsp_mapped_next = 1'b1;
        unique case (s1_kind_reg)
            K_DIRECT:
                rsp_offset_next = {6'b0, s1_low_reg};
            K_PRG_MEM:
                rsp_offset_next = {bank_value[bsam_pkg::PRG_BANK_W-1:0], s1_low_reg};
            K_PRG_FIXED:
                rsp_offset_next = {s1_fixed_reg, s1_low_reg};
            K_CHR:
                rsp_offset_next = {1'b0, bank_value, 10'b0} + {6'b0, s1_low_reg};
            default:
            begin
                rsp_offset_next = '0;
                rsp_mapped_next = 1'b0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (s1_advance)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance) begin
            rsp_offset_reg <= rsp_offset_next;
            rsp_mapped_reg <= rsp_mapped_next;
            rsp_mirror_reg <= s1_mirror_reg;
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign mapped_offset     = rsp_offset_reg;
    assign mapped_valid      = rsp_mapped_reg;
    assign mirror_horizontal = rsp_mirror_reg;

`ifndef SYNTHESIS
    property p_no_mem_collision;
        @(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re);
    endproperty
    a_no_mem_collision: assert property (p_no_mem_collision)
        else $error("bank memory read and write in the same cycle");

    property p_accept_fills_stage;
        @(posedge clk) disable iff (!rst_n)
        req_accept |=> s1_valid_reg;
    endproperty
    a_accept_fills_stage: assert property (p_accept_fills_stage)
        else $error("accepted transaction did not reach stage 1");

    property p_chr_2k_even;
        @(posedge clk) disable iff (!rst_n)
        (mem_we && mem_waddr <= bsam_pkg::BANK_CHR_2K_LAST) |-> !mem_wdata[0];
    endproperty
    a_chr_2k_even: assert property (p_chr_2k_even)
        else $error("2KB graphics bank loaded with an odd number");

    property p_unmapped_zero;
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_mapped_reg) |-> (rsp_offset_reg == '0);
    endproperty
    a_unmapped_zero: assert property (p_unmapped_zero)
        else $error("unmapped result carries a nonzero offset");
`endif

endmodule
